/* rtl/dec168_pkg.sv */
// Package for the (16,8) double-error-correcting decoder: parity-check rows,
// status codes, syndrome function and the syndrome-to-correction lookup table.
// No dependencies.
package dec168_pkg;

    localparam int CODE_BITS  = 16;
    localparam int SYN_BITS   = 8;
    localparam int DATA_BITS  = 8;
    localparam int POS_BITS   = 4;
    localparam int SYN_VALUES = 1 << SYN_BITS;

    typedef logic [CODE_BITS-1:0] word_t;
    typedef logic [SYN_BITS-1:0]  syn_t;
    typedef logic [POS_BITS-1:0]  pos_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_FAIL   = 2'd3
    } status_t;

    typedef struct packed {
        status_t st;
        pos_t    first;
        pos_t    second;
    } dec_entry_t;

    typedef dec_entry_t [SYN_VALUES-1:0] dec_table_t;

    // Row r of H; bit c is H[r][c].
    localparam word_t H_ROWS [SYN_BITS] = '{
        16'h010F, 16'h0233, 16'h0455, 16'h086A,
        16'h1097, 16'h20A9, 16'h40DE, 16'h80E7
    };

    function automatic syn_t calc_syndrome(word_t word);
        syn_t syn;
        syn = '0;
        for (int r = 0; r < SYN_BITS; r++)
        begin
            syn[r] = ^(word & H_ROWS[r]);
        end
        return syn;
    endfunction

    function automatic syn_t h_column(int c);
        syn_t col;
        col = '0;
        for (int r = 0; r < SYN_BITS; r++)
        begin
            col[r] = H_ROWS[r][c];
        end
        return col;
    endfunction

    // Evaluated at elaboration: singles first, then pairs in ascending order.
    function automatic dec_table_t build_dec_table();
        dec_table_t tbl;
        syn_t       cols [CODE_BITS];
        logic       found;
        for (int c = 0; c < CODE_BITS; c++)
        begin
            cols[c] = h_column(c);
        end
        for (int s = 0; s < SYN_VALUES; s++)
        begin
            tbl[s].st     = ST_NONE;
            tbl[s].first  = '0;
            tbl[s].second = '0;
            found = (s == 0);
            for (int i = 0; i < CODE_BITS; i++)
            begin
                if (!found && cols[i] == SYN_BITS'(s))
                begin
                    found        = 1'b1;
                    tbl[s].st    = ST_SINGLE;
                    tbl[s].first = POS_BITS'(i);
                end
            end
            for (int i = 0; i < CODE_BITS; i++)
            begin
                for (int j = i + 1; j < CODE_BITS; j++)
                begin
                    if (!found && (cols[i] ^ cols[j]) == SYN_BITS'(s))
                    begin
                        found         = 1'b1;
                        tbl[s].st     = ST_DOUBLE;
                        tbl[s].first  = POS_BITS'(i);
                        tbl[s].second = POS_BITS'(j);
                    end
                end
            end
            if (!found)
            begin
                tbl[s].st = ST_FAIL;
            end
        end
        return tbl;
    endfunction

    localparam dec_table_t DEC_TABLE = build_dec_table();

endpackage

/* rtl/double_error_correcting_decoder_16_8_top.sv */
// Top level of the (16,8) double-error-correcting decoder: four-stage pipeline
// (capture, syndrome, table lookup, bit flip). Depends on dec168_pkg.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, received_word              | into block
//  out     | out_valid, out_stall, corrected_word, data_byte,| out of block
//          | status, first_position, second_position        |
//
// One word per cycle sustained while out_stall is low; a word passes through the
// capture, syndrome, lookup and flip registers in order. Reset clears all stage
// valid bits. Each stage advances when the stage after it is empty or advancing,
// so a stall on the output fills bubbles first and then holds every stage.
module double_error_correcting_decoder_16_8_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dec168_pkg::CODE_BITS-1:0] received_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dec168_pkg::CODE_BITS-1:0] corrected_word,
    output logic [dec168_pkg::DATA_BITS-1:0] data_byte,
    output logic [1:0]                       status,
    output logic [dec168_pkg::POS_BITS-1:0]  first_position,
    output logic [dec168_pkg::POS_BITS-1:0]  second_position
);
    import dec168_pkg::*;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    word_t      s1_word_reg, s2_word_reg, s3_word_reg;
    syn_t       s2_syn_reg;
    dec_entry_t s3_entry_reg;
    word_t      out_word_reg;
    status_t    out_status_reg;
    pos_t       out_first_reg, out_second_reg;

    logic       en_out, en3, en2, en1;
    word_t      flip_mask_next;
    word_t      out_word_next;

    assign en_out = !out_valid_reg || !out_stall;
    assign en3    = !s3_valid_reg || en_out;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    assign in_stall = !en1;

    always_comb
    begin
        flip_mask_next = '0;
        case (s3_entry_reg.st)
            ST_SINGLE:
            begin
                flip_mask_next = word_t'(1) << s3_entry_reg.first;
            end
            ST_DOUBLE:
            begin
                flip_mask_next = (word_t'(1) << s3_entry_reg.first)
                               | (word_t'(1) << s3_entry_reg.second);
            end
            default:
            begin
                flip_mask_next = '0;
            end
        endcase
        out_word_next = s3_word_reg ^ flip_mask_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_word_reg <= received_word;
        end
        if (en2)
        begin
            s2_word_reg <= s1_word_reg;
            s2_syn_reg  <= calc_syndrome(s1_word_reg);
        end
        if (en3)
        begin
            s3_word_reg  <= s2_word_reg;
            s3_entry_reg <= DEC_TABLE[s2_syn_reg];
        end
        if (en_out)
        begin
            out_word_reg   <= out_word_next;
            out_status_reg <= s3_entry_reg.st;
            out_first_reg  <= s3_entry_reg.first;
            out_second_reg <= s3_entry_reg.second;
        end
    end

    assign out_valid       = out_valid_reg;
    assign corrected_word  = out_word_reg;
    assign data_byte       = out_word_reg[DATA_BITS-1:0];
    assign status          = out_status_reg;
    assign first_position  = out_first_reg;
    assign second_position = out_second_reg;

    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word did not enter capture stage");

    a_no_flip_no_pos : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status_reg == ST_NONE || out_status_reg == ST_FAIL))
        |-> (first_position == '0 && second_position == '0))
        else $error("positions set without a correction");

    a_single_pos : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status_reg == ST_SINGLE) |-> (second_position == '0))
        else $error("second position set on single correction");

    a_double_order : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status_reg == ST_DOUBLE) |-> (first_position < second_position))
        else $error("double correction positions out of order");

    a_hold_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && out_valid_reg && out_stall) |=> s3_valid_reg)
        else $error("lookup stage dropped a word under stall");

endmodule

/* bench/tb_double_error_correcting_decoder_16_8_top.sv */
// Testbench for the (16,8) double-error-correcting decoder top level: directed
// table plus random codewords with injected bit errors, scored by a local decoder.
// Depends on dec168_pkg and double_error_correcting_decoder_16_8_top.
`timescale 1ns / 100ps

module tb_double_error_correcting_decoder_16_8_top;

    import dec168_pkg::*;

    localparam int RAND_PER_PHASE = 300;
    localparam int BURST_WORDS    = 40;
    localparam int HOLD_CYCLES    = 60;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DIR_ROWS       = 24;

    // Parity-check rows; bit c of row r is H[r][c].
    localparam logic [15:0] CHECK_ROWS [8] = '{
        16'h010F, 16'h0233, 16'h0455, 16'h086A,
        16'h1097, 16'h20A9, 16'h40DE, 16'h80E7
    };

    typedef struct packed {
        word_t     fixed;
        logic [7:0] data;
        status_t   st;
        pos_t      p1;
        pos_t      p2;
    } fix_t;

    typedef struct packed {
        word_t word;
        bit    typed;
        fix_t  want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    word_t      received_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    word_t      corrected_word;
    logic [7:0] data_byte;
    logic [1:0] status;
    pos_t       first_position;
    pos_t       second_position;

    fix_t      pending_fixes [$];
    stim_row_t dir_tab [DIR_ROWS];
    fix_t      oldest;
    int        mismatches = 0;
    int        status_seen [4] = '{0, 0, 0, 0};
    int        words_sent = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        idle_cycles = 0;
    bit        hold_req = 1'b0;
    logic      long_hold = 1'b0;

    double_error_correcting_decoder_16_8_top uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .received_word   (received_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .corrected_word  (corrected_word),
        .data_byte       (data_byte),
        .status          (status),
        .first_position  (first_position),
        .second_position (second_position)
    );

    always #5 clk = ~clk;

    function automatic fix_t decode_word(input word_t w);
        fix_t res;
        syn_t syn;
        syn_t col [16];
        bit   hit;
        syn = '0;
        for (int k = 0; k < 8; k++)
        begin
            syn[k] = ^(w & CHECK_ROWS[k]);
        end
        for (int c = 0; c < 16; c++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                col[c][k] = CHECK_ROWS[k][c];
            end
        end
        res.fixed = w;
        res.st    = ST_NONE;
        res.p1    = '0;
        res.p2    = '0;
        hit = (syn == '0);
        // single-bit match wins over any pair
        for (int i = 0; i < 16; i++)
        begin
            if (!hit && col[i] == syn)
            begin
                hit       = 1'b1;
                res.st    = ST_SINGLE;
                res.p1    = pos_t'(i);
                res.fixed = w ^ (word_t'(1) << i);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            for (int j = i + 1; j < 16; j++)
            begin
                if (!hit && (col[i] ^ col[j]) == syn)
                begin
                    hit       = 1'b1;
                    res.st    = ST_DOUBLE;
                    res.p1    = pos_t'(i);
                    res.p2    = pos_t'(j);
                    res.fixed = w ^ (word_t'(1) << i) ^ (word_t'(1) << j);
                end
            end
        end
        if (!hit)
        begin
            res.st = ST_FAIL;
        end
        res.data = res.fixed[7:0];
        return res;
    endfunction

    // Parity bit 8+k appears only in row k, so it is the parity of the data part.
    function automatic word_t encode_byte(input logic [7:0] d);
        word_t w;
        w = {8'h00, d};
        for (int k = 0; k < 8; k++)
        begin
            w[8 + k] = ^({8'h00, d} & CHECK_ROWS[k]);
        end
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        word_t flips;
        int    pick;
        int    nerr;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            return word_t'($urandom);
        end
        w = encode_byte(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 15)
            nerr = 0;
        else if (pick < 45)
            nerr = 1;
        else if (pick < 80)
            nerr = 2;
        else
            nerr = $urandom_range(5, 3);
        flips = '0;
        while ($countones(flips) < nerr)
        begin
            flips[$urandom_range(15)] = 1'b1;
        end
        return w ^ flips;
    endfunction

    task automatic send_word(input word_t w, input fix_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        received_word <= w;
        do
            @(posedge clk);
        while (in_stall);
        pending_fixes = {pending_fixes, want};
        words_sent++;
    endtask

    // Hold the input side idle until every word in flight has come out.
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_fixes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Receiver side: random stall, forced high during the long hold-off.
    always @(posedge clk)
    begin
        out_stall <= long_hold || ($urandom_range(99) < rx_stall_pct);
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            status_seen[status]++;
            if (pending_fixes.size() == 0)
            begin
                report_mismatch("unexpected transfer, word", int'(corrected_word), 0);
            end
            else
            begin
                oldest = pending_fixes.pop_front();
                if (corrected_word !== oldest.fixed)
                    report_mismatch("corrected_word", int'(corrected_word),
                                    int'(oldest.fixed));
                if (data_byte !== oldest.data)
                    report_mismatch("data_byte", int'(data_byte), int'(oldest.data));
                if (status !== oldest.st)
                    report_mismatch("status", int'(status), int'(oldest.st));
                if (first_position !== oldest.p1)
                    report_mismatch("first_position", int'(first_position),
                                    int'(oldest.p1));
                if (second_position !== oldest.p2)
                    report_mismatch("second_position", int'(second_position),
                                    int'(oldest.p2));
            end
        end
    end

    // Abort when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("double_error_correcting_decoder_16_8_top verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        dir_tab[0] = '{16'h0000, 1'b1, '{16'h0000, 8'h00, ST_NONE, 4'd0, 4'd0}};
        for (int k = 0; k < 16; k++)
        begin
            dir_tab[k + 1] = '{word_t'(1) << k, 1'b1,
                               '{16'h0000, 8'h00, ST_SINGLE, pos_t'(k), 4'd0}};
        end
        dir_tab[17] = '{16'hFFFF, 1'b0, '0};
        dir_tab[18] = '{16'h0003, 1'b0, '0};
        dir_tab[19] = '{16'h8001, 1'b0, '0};
        dir_tab[20] = '{16'hC000, 1'b0, '0};
        dir_tab[21] = '{16'h00FF, 1'b0, '0};
        dir_tab[22] = '{16'hFF00, 1'b0, '0};
        dir_tab[23] = '{16'h5555, 1'b0, '0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[n])
        begin
            send_word(dir_tab[n].word,
                      dir_tab[n].typed ? dir_tab[n].want : decode_word(dir_tab[n].word));
        end
        drain_all();

        // idle patterns: none, sender 83%, receiver 83%, both 17%
        for (int mode = 0; mode < 4; mode++)
        begin
            tx_idle_pct  = (mode == 1) ? 83 : (mode == 3) ? 17 : 0;
            rx_stall_pct = (mode == 2) ? 83 : (mode == 3) ? 17 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                word_t w;
                w = random_word();
                send_word(w, decode_word(w));
            end
            if (mode == 0)
            begin
                // long output hold-off while words keep coming: fill the pipe
                hold_req = 1'b1;
                for (int n = 0; n < BURST_WORDS; n++)
                begin
                    word_t w;
                    w = random_word();
                    send_word(w, decode_word(w));
                end
            end
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Decoded %0d words: %0d clean, %0d single fixes, %0d double fixes,",
                 words_sent, status_seen[0], status_seen[1], status_seen[2]);
        $display("%0d uncorrectable; four idle patterns and one long output hold-off",
                 status_seen[3]);
        if (mismatches == 0)
        begin
            $display("double_error_correcting_decoder_16_8_top verification clean");
        end
        else
        begin
            $display("double_error_correcting_decoder_16_8_top verification failed");
        end
        $finish;
    end

endmodule
